// File: design/bis_pkg.sv
// ============================================================================
// bis_pkg
// Shared types and constants of the bilinear image sampler: word layouts
// between the front end, the job queue and the sampling back end.
// ============================================================================
`default_nettype none

package bis_pkg;

    localparam int COORD_W    = 21;   // sample coordinate width
    localparam int PIX_W      = 8;    // pixel width
    localparam int INT_W      = 16;   // result intensity width
    localparam int OUT_FRAC   = 8;    // fraction bits of the result
    localparam int DIM_W      = 10;   // width of a dimension register write
    localparam int HALF_W     = 11;   // bank row/column index, largest store
    localparam int WGT_W      = 16;   // weight field, largest fraction
    localparam int MID_DEPTH  = 4;    // job queue depth
    localparam int OUT_DEPTH  = 8;    // result queue depth
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic tl;
        logic tr;
        logic bl;
        logic br;
    } t_taps;

    typedef struct packed {
        logic              is_sample;
        logic              last;
        logic              ld_ok;
        logic [PIX_W-1:0]  pix;
        logic [HALF_W-1:0] row_ev;
        logic [HALF_W-1:0] row_od;
        logic [HALF_W-1:0] col_ev;
        logic [HALF_W-1:0] col_od;
        logic              fy0;
        logic              fx0;
        logic [WGT_W-1:0]  wx;
        logic [WGT_W-1:0]  wy;
        t_taps             tap_on;
    } t_job;

    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic             end_of_set;
    } t_result;

    typedef struct packed {
        logic       res_vld;
        logic [1:0] inflight;
    } t_back_stat;

endpackage

`default_nettype wire

// File: design/bis_fifo.sv
// ============================================================================
// bis_fifo
// Small register queue with first-word-fall-through read and a fill count.
// ============================================================================
`default_nettype none

module bis_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_wdata,
    output logic                                o_full,
    input  wire logic                           i_pop,
    output logic [WIDTH-1:0]                    o_rdata,
    output logic                                o_empty,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    always_comb begin
        do_push = i_push && (r_cnt != CW'(DEPTH));
        do_pop  = i_pop && (r_cnt != '0);
        n_wp    = r_wp;
        n_rp    = r_rp;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// File: design/bis_front.sv
// ============================================================================
// bis_front
// Classifies an input word: a load becomes a store write, a sample is split
// into floor, weight, bounds checks and parity bank indexes.
// ============================================================================
`default_nettype none

module bis_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                i_mode,
    input  wire logic [bis_pkg::PIX_W-1:0]           i_pixel_value,
    input  wire logic [8:0]                          i_pixel_col,
    input  wire logic [8:0]                          i_pixel_row,
    input  wire logic signed [bis_pkg::COORD_W-1:0]  i_sample_x,
    input  wire logic signed [bis_pkg::COORD_W-1:0]  i_sample_y,
    input  wire logic                                i_last_sample,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      i_width,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     i_height,
    output bis_pkg::t_job                            o_job
);

    import bis_pkg::*;

    logic signed [COORD_W-1:0] fx_full, fy_full;
    logic [COORD_W-1:0]        fx_u, fy_u;
    logic [COORD_W-1:0]        wmax_e, hmax_e;
    logic [FRAC_BITS-1:0]      wx, wy;
    logic                      fx_ok, fy_ok, rx_ok, ry_ok;
    logic                      wx_nz, wy_nz;
    logic [HALF_W-1:0]         fx_half, fy_half;
    logic [HALF_W-1:0]         ld_col_half, ld_row_half;

    always_comb begin
        fx_full = i_sample_x >>> FRAC_BITS;
        fy_full = i_sample_y >>> FRAC_BITS;
        fx_u    = fx_full;
        fy_u    = fy_full;
        wx      = i_sample_x[FRAC_BITS-1:0];
        wy      = i_sample_y[FRAC_BITS-1:0];
        wx_nz   = |wx;
        wy_nz   = |wy;
        wmax_e  = COORD_W'(i_width) - 1'b1;
        hmax_e  = COORD_W'(i_height) - 1'b1;

        fx_ok = !i_sample_x[COORD_W-1] && (fx_u <= wmax_e);
        fy_ok = !i_sample_y[COORD_W-1] && (fy_u <= hmax_e);
        // raw coordinate up to (max index) with a zero fraction
        rx_ok = !i_sample_x[COORD_W-1] && ((fx_u < wmax_e) || ((fx_u == wmax_e) && !wx_nz));
        ry_ok = !i_sample_y[COORD_W-1] && ((fy_u < hmax_e) || ((fy_u == hmax_e) && !wy_nz));

        fx_half     = fx_full[HALF_W:1];
        fy_half     = fy_full[HALF_W:1];
        ld_col_half = HALF_W'(i_pixel_col[8:1]);
        ld_row_half = HALF_W'(i_pixel_row[8:1]);

        o_job = '0;
        o_job.last = i_last_sample;
        o_job.pix  = i_pixel_value;
        if (i_mode == MODE_LOAD) begin
            o_job.is_sample = 1'b0;
            o_job.ld_ok     = (32'(i_pixel_col) < MAX_WIDTH) && (32'(i_pixel_row) < MAX_HEIGHT);
            o_job.row_ev    = ld_row_half;
            o_job.row_od    = ld_row_half;
            o_job.col_ev    = ld_col_half;
            o_job.col_od    = ld_col_half;
            o_job.fy0       = i_pixel_row[0];
            o_job.fx0       = i_pixel_col[0];
        end else begin
            o_job.is_sample = 1'b1;
            // even bank holds whichever of floor and floor+1 is even
            o_job.row_ev    = fy_half + HALF_W'(fy_full[0]);
            o_job.row_od    = fy_half;
            o_job.col_ev    = fx_half + HALF_W'(fx_full[0]);
            o_job.col_od    = fx_half;
            o_job.fy0       = fy_full[0];
            o_job.fx0       = fx_full[0];
            o_job.wx        = WGT_W'(wx);
            o_job.wy        = WGT_W'(wy);
            // a tap with zero weight is gated off, its value never matters
            o_job.tap_on.tl = fx_ok && fy_ok;
            o_job.tap_on.tr = rx_ok && fy_ok && wx_nz;
            o_job.tap_on.bl = fx_ok && ry_ok && wy_nz;
            o_job.tap_on.br = rx_ok && ry_ok && wx_nz && wy_nz;
        end
    end

endmodule

`default_nettype wire

// File: design/bis_back.sv
// ============================================================================
// bis_back
// Image store in four row/column parity banks and the blend pipeline:
// bank read, horizontal blend, vertical blend, rounding.
// ============================================================================
`default_nettype none

module bis_back #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_issue,
    input  wire bis_pkg::t_job       i_job,
    output bis_pkg::t_result         o_res,
    output bis_pkg::t_back_stat      o_stat
);

    import bis_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int CWD    = $clog2(MAX_WIDTH);
    localparam int RHW    = (RW > 1) ? RW - 1 : 1;
    localparam int CHW    = (CWD > 1) ? CWD - 1 : 1;
    localparam int AW     = RHW + CHW;
    localparam int BANK_D = 1 << AW;
    localparam int TOP_W  = F + PIX_W;
    localparam int V_W    = 2 * F + PIX_W;
    localparam int SH     = 2 * F - OUT_FRAC;

    // bank index is {row parity, column parity}
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] PAR = 2'(b);
        logic [PIX_W-1:0]  mem [BANK_D];
        logic [PIX_W-1:0]  r_q;
        logic [HALF_W-1:0] row_sel, col_sel;
        logic [AW-1:0]     addr;
        logic              we, re;

        always_comb begin
            row_sel = PAR[1] ? i_job.row_od : i_job.row_ev;
            col_sel = PAR[0] ? i_job.col_od : i_job.col_ev;
            addr    = {row_sel[RHW-1:0], col_sel[CHW-1:0]};
            we      = i_issue && !i_job.is_sample && i_job.ld_ok
                      && ({i_job.fy0, i_job.fx0} == PAR);
            re      = i_issue && i_job.is_sample;
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[addr] <= i_job.pix;
            end
            if (re) begin
                r_q <= mem[addr];
            end
        end
    end

    // stage 1: bank data arrives
    logic          r_s1_vld, r_s1_last, r_s1_fy0, r_s1_fx0;
    logic [F-1:0]  r_s1_wx, r_s1_wy;
    t_taps         r_s1_on;
    // stage 2: horizontal blends
    logic             r_s2_vld, r_s2_last;
    logic [TOP_W-1:0] r_s2_top, r_s2_bot, n_top, n_bot;
    logic [F-1:0]     r_s2_wy;
    // stage 3: vertical blend
    logic             r_s3_vld, r_s3_last;
    logic [V_W-1:0]   r_s3_v, n_v;

    logic [PIX_W-1:0]          tl, tr, bl, br;
    logic signed [F:0]         wxs, wys;
    logic signed [PIX_W:0]     dtop, dbot;
    logic signed [F+PIX_W+1:0] ptop, pbot;
    logic signed [TOP_W:0]     dv;
    logic signed [F+TOP_W+1:0] pv;
    logic [INT_W-1:0]          res_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_issue && i_job.is_sample;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_job.last;
        r_s1_fy0  <= i_job.fy0;
        r_s1_fx0  <= i_job.fx0;
        r_s1_wx   <= i_job.wx[F-1:0];
        r_s1_wy   <= i_job.wy[F-1:0];
        r_s1_on   <= i_job.tap_on;
        r_s2_last <= r_s1_last;
        r_s2_top  <= n_top;
        r_s2_bot  <= n_bot;
        r_s2_wy   <= r_s1_wy;
        r_s3_last <= r_s2_last;
        r_s3_v    <= n_v;
    end

    always_comb begin
        unique case ({r_s1_fy0, r_s1_fx0})
            2'b00: begin
                tl = g_bank[0].r_q; tr = g_bank[1].r_q;
                bl = g_bank[2].r_q; br = g_bank[3].r_q;
            end
            2'b01: begin
                tl = g_bank[1].r_q; tr = g_bank[0].r_q;
                bl = g_bank[3].r_q; br = g_bank[2].r_q;
            end
            2'b10: begin
                tl = g_bank[2].r_q; tr = g_bank[3].r_q;
                bl = g_bank[0].r_q; br = g_bank[1].r_q;
            end
            default: begin
                tl = g_bank[3].r_q; tr = g_bank[2].r_q;
                bl = g_bank[1].r_q; br = g_bank[0].r_q;
            end
        endcase
        if (!r_s1_on.tl) tl = '0;
        if (!r_s1_on.tr) tr = '0;
        if (!r_s1_on.bl) bl = '0;
        if (!r_s1_on.br) br = '0;

        // a*(S-w) + b*w folded to a*S + w*(b-a)
        wxs   = $signed({1'b0, r_s1_wx});
        dtop  = $signed({1'b0, tr}) - $signed({1'b0, tl});
        dbot  = $signed({1'b0, br}) - $signed({1'b0, bl});
        ptop  = wxs * dtop;
        pbot  = wxs * dbot;
        n_top = TOP_W'($signed({2'b00, tl, {F{1'b0}}}) + ptop);
        n_bot = TOP_W'($signed({2'b00, bl, {F{1'b0}}}) + pbot);

        wys = $signed({1'b0, r_s2_wy});
        dv  = $signed({1'b0, r_s2_bot}) - $signed({1'b0, r_s2_top});
        pv  = wys * dv;
        n_v = V_W'($signed({2'b00, r_s2_top, {F{1'b0}}}) + pv);
    end

    if (SH > 0) begin : g_round
        localparam logic [V_W:0] RND_HALF = {{V_W{1'b0}}, 1'b1} << (SH - 1);
        logic [V_W:0] vr;
        // round to nearest, ties upward
        assign vr      = {1'b0, r_s3_v} + RND_HALF;
        assign res_int = vr[SH+INT_W-1:SH];
    end else begin : g_exact
        assign res_int = r_s3_v[INT_W-1:0];
    end

    always_comb begin
        o_res.intensity  = res_int;
        o_res.end_of_set = r_s3_last;
        o_stat.res_vld   = r_s3_vld;
        o_stat.inflight  = 2'(r_s1_vld) + 2'(r_s2_vld) + 2'(r_s3_vld);
    end

endmodule

`default_nettype wire

// File: design/bilinear_image_sampler.sv
// ============================================================================
// bilinear_image_sampler
// Throughput: one word per cycle, loads and samples alike, while the result
//   queue has room for every word in flight; the four taps of a sample come
//   from four parity banks of the image store in one read. A sample word is
//   blended, rounded and put in the result queue; a load word gives no result.
// Reset: synchronous, active low; clears queues, pipeline valids and the size
//   registers (512 x 512, capped at the store size); the image store is kept.
// ============================================================================
`default_nettype none

module bilinear_image_sampler #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input queue side
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                i_mode,
    input  wire logic [bis_pkg::PIX_W-1:0]           i_pixel_value,
    input  wire logic [8:0]                          i_pixel_col,
    input  wire logic [8:0]                          i_pixel_row,
    input  wire logic signed [bis_pkg::COORD_W-1:0]  i_sample_x,
    input  wire logic signed [bis_pkg::COORD_W-1:0]  i_sample_y,
    input  wire logic                                i_last_sample,
    // result queue side
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [bis_pkg::INT_W-1:0]                o_intensity,
    output logic                                     o_end_of_set,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    import bis_pkg::*;

    localparam int DWW   = $clog2(MAX_WIDTH + 1);
    localparam int DHW   = $clog2(MAX_HEIGHT + 1);
    localparam int MCW   = $clog2(MID_DEPTH + 1);
    localparam int W_RST = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam int H_RST = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

    logic [DWW-1:0]   r_width, n_width;
    logic [DHW-1:0]   r_height, n_height;
    logic [DIM_W-1:0] cfg_val;
    logic             cfg_wr;

    t_job                  job_in, mid_job;
    logic [$bits(t_job)-1:0] mid_rdata;
    logic                  mid_full, mid_empty;
    logic [MCW-1:0]        mid_cnt;
    logic                  issue, issue_sample;

    t_result               res;
    t_back_stat            stat;
    logic [$bits(t_result)-1:0] out_rdata;
    t_result               out_word;
    logic                  out_full;
    logic [OUT_CNT_W-1:0]  out_cnt;
    logic [OUT_CNT_W:0]    outstanding;

    // ---------------- configuration ----------------
    always_comb begin
        cfg_wr  = psel && penable && pwrite && pready;
        cfg_val = pwdata[DIM_W-1:0];

        if (cfg_val == '0) begin
            n_width = DWW'(1);
        end else if (32'(cfg_val) > MAX_WIDTH) begin
            n_width = DWW'(MAX_WIDTH);
        end else begin
            n_width = DWW'(cfg_val);
        end

        if (cfg_val == '0) begin
            n_height = DHW'(1);
        end else if (32'(cfg_val) > MAX_HEIGHT) begin
            n_height = DHW'(MAX_HEIGHT);
        end else begin
            n_height = DHW'(cfg_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DWW'(W_RST);
            r_height <= DHW'(H_RST);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= n_width;
            end else begin
                r_height <= n_height;
            end
        end
    end

    always_comb begin
        pready = 1'b1;
        if (paddr[2] == REG_HEIGHT) begin
            prdata = 32'(r_height);
        end else begin
            prdata = 32'(r_width);
        end
    end

    // ---------------- front end and job queue ----------------
    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_mode        (i_mode),
        .i_pixel_value (i_pixel_value),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_last_sample (i_last_sample),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_job         (job_in)
    );

    bis_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (job_in),
        .o_full  (mid_full),
        .i_pop   (issue),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty),
        .o_count (mid_cnt)
    );

    assign full    = mid_full;
    assign mid_job = mid_rdata;

    // issue only while the result queue can absorb every word in flight
    always_comb begin
        outstanding  = (OUT_CNT_W+1)'(out_cnt) + (OUT_CNT_W+1)'(stat.inflight);
        issue        = !mid_empty && (outstanding < (OUT_CNT_W+1)'(OUT_DEPTH));
        issue_sample = issue && mid_job.is_sample;
    end

    // ---------------- back end and result queue ----------------
    bis_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_job   (mid_job),
        .o_res   (res),
        .o_stat  (stat)
    );

    bis_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (stat.res_vld),
        .i_wdata (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty),
        .o_count (out_cnt)
    );

    assign out_word     = out_rdata;
    assign o_intensity  = out_word.intensity;
    assign o_end_of_set = out_word.end_of_set;

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outstanding <= (OUT_CNT_W+1)'(OUT_DEPTH))
        else $error("words in flight exceed result queue space");

    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_vld |-> !out_full)
        else $error("result written into a full result queue");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_vld |-> $past(issue_sample, 3))
        else $error("result without a sample issued three cycles earlier");

    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_cnt <= MCW'(MID_DEPTH))
        else $error("job queue holds more words than its depth");

endmodule

`default_nettype wire

// File: dv/tb_bilinear_image_sampler.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_bilinear_image_sampler
// Loads images through the input queue and samples them at signed Q.8
// coordinates, checking every intensity word against an in-bench bilinear
// predictor with zero border. Covers size register limits, edge taps and
// random sets under random and long result back-pressure.
// ============================================================================

module tb_bilinear_image_sampler;
    import bis_pkg::*;

    localparam int STORE_COLS    = 512;
    localparam int STORE_ROWS    = 512;
    localparam int FRAC          = 8;
    localparam int ONE           = 1 << FRAC;
    localparam int ROUND_SHIFT   = 2 * FRAC - OUT_FRAC;
    localparam int COORD_MAX     = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN     = -(1 << (COORD_W - 1));
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_WORDS   = 440;
    localparam int HOLD_CYCLES   = 300;

    localparam int TAP_TL = 0;
    localparam int TAP_TR = 1;
    localparam int TAP_BL = 2;
    localparam int TAP_BR = 3;

    typedef struct {
        logic                      mode;
        logic [PIX_W-1:0]          value;
        logic [8:0]                col;
        logic [8:0]                row;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_word;

    // taps a sample reads, with the fraction weights
    typedef struct packed {
        logic [3:0]      en;
        logic [3:0][9:0] row;
        logic [3:0][9:0] col;
        logic [7:0]      wx;
        logic [7:0]      wy;
    } t_footprint;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      push          = 1'b0;
    logic                      i_mode        = MODE_LOAD;
    logic [PIX_W-1:0]          i_pixel_value = '0;
    logic [8:0]                i_pixel_col   = '0;
    logic [8:0]                i_pixel_row   = '0;
    logic signed [COORD_W-1:0] i_sample_x    = '0;
    logic signed [COORD_W-1:0] i_sample_y    = '0;
    logic                      i_last_sample = 1'b0;
    logic                      pop           = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [2:0]                paddr         = '0;
    logic [31:0]               pwdata        = '0;
    logic                      full;
    logic                      empty;
    logic [INT_W-1:0]          o_intensity;
    logic                      o_end_of_set;
    logic [31:0]               prdata;
    logic                      pready;

    logic [PIX_W-1:0] pix_mem    [STORE_ROWS*STORE_COLS];
    bit               pix_loaded [STORE_ROWS*STORE_COLS];
    int               img_w = 512;
    int               img_h = 512;
    t_result          expected_q[$];
    int               errors        = 0;
    int               words_sent    = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_left     = 0;

    bilinear_image_sampler uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_pixel_value(i_pixel_value),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .i_last_sample(i_last_sample),
        .empty        (empty),
        .pop          (pop),
        .o_intensity  (o_intensity),
        .o_end_of_set (o_end_of_set),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pix_addr(input int row, input int col);
        return row * STORE_COLS + col;
    endfunction

    function automatic int effective_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0) return 1;
        return (raw > 512) ? 512 : int'(raw);
    endfunction

    function automatic t_footprint footprint(input logic signed [COORD_W-1:0] sx,
                                             input logic signed [COORD_W-1:0] sy);
        longint     x, y, fx, fy, cx, cy;
        logic       fx_ok, fy_ok, rx_ok, ry_ok;
        t_footprint fp;
        x = longint'(sx);
        y = longint'(sy);
        fx = x >>> FRAC;
        fy = y >>> FRAC;
        fp.wx = x[FRAC-1:0];
        fp.wy = y[FRAC-1:0];
        cx = (fp.wx != 0) ? fx + 1 : fx;
        cy = (fp.wy != 0) ? fy + 1 : fy;
        fx_ok = fx >= 0 && fx < img_w;
        fy_ok = fy >= 0 && fy < img_h;
        // right and bottom taps are gated on the raw coordinate
        rx_ok = x >= 0 && x <= longint'(img_w - 1) * ONE;
        ry_ok = y >= 0 && y <= longint'(img_h - 1) * ONE;
        fp.en[TAP_TL] = fx_ok && fy_ok;
        fp.en[TAP_TR] = rx_ok && fy_ok;
        fp.en[TAP_BL] = fx_ok && ry_ok;
        fp.en[TAP_BR] = rx_ok && ry_ok;
        fp.row[TAP_TL] = fy[9:0];
        fp.col[TAP_TL] = fx[9:0];
        fp.row[TAP_TR] = fy[9:0];
        fp.col[TAP_TR] = cx[9:0];
        fp.row[TAP_BL] = cy[9:0];
        fp.col[TAP_BL] = fx[9:0];
        fp.row[TAP_BR] = cy[9:0];
        fp.col[TAP_BR] = cx[9:0];
        return fp;
    endfunction

    function automatic int tap_value(input t_footprint fp, input int k);
        if (!fp.en[k]) return 0;
        return int'(pix_mem[pix_addr(int'(fp.row[k]), int'(fp.col[k]))]);
    endfunction

    function automatic logic [INT_W-1:0] bilinear_intensity(input t_footprint fp);
        int wx, wy, top, bot, v;
        wx = int'(fp.wx);
        wy = int'(fp.wy);
        top = (ONE - wx) * tap_value(fp, TAP_TL) + wx * tap_value(fp, TAP_TR);
        bot = (ONE - wx) * tap_value(fp, TAP_BL) + wx * tap_value(fp, TAP_BR);
        v = (ONE - wy) * top + wy * bot;
        return INT_W'((v + (1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input int dim);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return COORD_W'($urandom_range(0, (dim + 1) * ONE) - ONE);
            5: return COORD_W'($urandom_range(0, dim - 1) * ONE);
            6, 7: return COORD_W'((dim - 1) * ONE + $urandom_range(0, ONE - 1));
            8: return COORD_W'(-$urandom_range(1, ONE));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // one word onto the input queue; push stays high on return
    task automatic send_word(input t_word w);
        t_footprint fp;
        t_result    want;
        int         addr;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_mode        <= w.mode;
        i_pixel_value <= w.value;
        i_pixel_col   <= w.col;
        i_pixel_row   <= w.row;
        i_sample_x    <= w.x;
        i_sample_y    <= w.y;
        i_last_sample <= w.last;
        do @(posedge i_clk); while (full);
        if (w.mode == MODE_LOAD) begin
            addr = pix_addr(int'(w.row), int'(w.col));
            pix_mem[addr] = w.value;
            pix_loaded[addr] = 1'b1;
        end else begin
            fp = footprint(w.x, w.y);
            want.intensity = bilinear_intensity(fp);
            want.end_of_set = w.last;
            expected_q.push_back(want);
        end
        words_sent++;
    endtask

    task automatic load_pixel(input int row, input int col, input logic [PIX_W-1:0] val);
        t_word w;
        w.mode  = MODE_LOAD;
        w.value = val;
        w.col   = 9'(col);
        w.row   = 9'(row);
        w.x     = COORD_W'($urandom);
        w.y     = COORD_W'($urandom);
        w.last  = 1'($urandom);
        send_word(w);
    endtask

    // loads any tap the sample would read that holds nothing yet
    task automatic sample_point(input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y, input logic last);
        t_footprint fp;
        t_word      w;
        int         k;
        fp = footprint(x, y);
        for (k = 0; k < 4; k++) begin
            if (fp.en[k] && !pix_loaded[pix_addr(int'(fp.row[k]), int'(fp.col[k]))])
                load_pixel(int'(fp.row[k]), int'(fp.col[k]), PIX_W'($urandom));
        end
        w.mode  = MODE_SAMPLE;
        w.value = PIX_W'($urandom);
        w.col   = 9'($urandom);
        w.row   = 9'($urandom);
        w.x     = x;
        w.y     = y;
        w.last  = last;
        send_word(w);
    endtask

    task automatic fill_image();
        int r, c;
        for (r = 0; r < img_h; r++)
            for (c = 0; c < img_w; c++)
                load_pixel(r, c, PIX_W'($urandom));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
        logic [31:0] data;
        data = $urandom;
        data[DIM_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH) img_w = effective_dim(val);
        else img_h = effective_dim(val);
        @(posedge i_clk);
    endtask

    task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        drain_results();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic check_result();
        t_result want;
        if (expected_q.size() == 0) begin
            $error("intensity: expected no word, got %0d", o_intensity);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (o_intensity !== want.intensity) begin
            $error("intensity: expected %0d, got %0d", want.intensity, o_intensity);
            errors++;
        end
        if (o_end_of_set !== want.end_of_set) begin
            $error("end_of_set: expected %0b, got %0b", want.end_of_set, o_end_of_set);
            errors++;
        end
    endtask

    // runs on the default 512 x 512 size left by reset
    task automatic test_reset_size_corners();
        load_pixel(0, 0, 8'hFF);
        load_pixel(0, 1, 8'h00);
        load_pixel(1, 0, 8'h80);
        load_pixel(1, 1, 8'h01);
        load_pixel(511, 511, 8'hFF);
        load_pixel(511, 510, 8'hC8);
        load_pixel(510, 511, 8'h11);
        load_pixel(510, 510, 8'h00);
        sample_point(COORD_W'(0), COORD_W'(0), 1'b0);
        sample_point(COORD_W'(ONE / 2), COORD_W'(ONE / 2), 1'b0);
        sample_point(COORD_W'(ONE / 4), COORD_W'(3 * ONE / 4), 1'b1);
        sample_point(COORD_W'(-1), COORD_W'(0), 1'b0);
        sample_point(COORD_W'(-ONE / 2), COORD_W'(-ONE / 2), 1'b0);
        sample_point(COORD_W'(511 * ONE), COORD_W'(511 * ONE), 1'b0);
        sample_point(COORD_W'(511 * ONE - 1), COORD_W'(511 * ONE - 1), 1'b1);
        sample_point(COORD_W'(511 * ONE + 1), COORD_W'(510 * ONE), 1'b0);
        sample_point(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), 1'b0);
        sample_point(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), 1'b1);
    endtask

    task automatic test_dimension_limits();
        set_image_size(DIM_W'(0), DIM_W'(0));
        // outside the 1 x 1 image but inside the store, must be kept
        load_pixel(300, 5, 8'h4D);
        sample_point(COORD_W'(0), COORD_W'(0), 1'b0);
        sample_point(COORD_W'(ONE / 2), COORD_W'(ONE / 2), 1'b1);
        set_image_size(10'h3FF, 10'h3FF);
        sample_point(COORD_W'(5 * ONE), COORD_W'(300 * ONE), 1'b0);
        sample_point(COORD_W'(5 * ONE + ONE / 2), COORD_W'(300 * ONE + 3), 1'b1);
    endtask

    task automatic test_random_sets(input int quota);
        int stop_at, n, i;
        logic [DIM_W-1:0] dim [2];
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            for (i = 0; i < 2; i++) begin
                case ($urandom_range(15))
                    0: dim[i] = DIM_W'(0);
                    1: dim[i] = DIM_W'(1);
                    2: dim[i] = DIM_W'(512);
                    3: dim[i] = 10'h3FF;
                    4: dim[i] = DIM_W'($urandom_range(0, 1023));
                    default: dim[i] = DIM_W'($urandom_range(2, 12));
                endcase
            end
            set_image_size(dim[0], dim[1]);
            if (img_w * img_h <= 96) fill_image();
            n = int'($urandom_range(12, 48));
            for (i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0)
                    load_pixel(int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
                               PIX_W'($urandom));
                sample_point(pick_coord(img_w), pick_coord(img_h),
                             (i == n - 1) || ($urandom_range(7) == 0));
            end
        end
    endtask

    // results held back long enough for both queues to fill and push to stall
    task automatic test_backpressure();
        set_image_size(DIM_W'(4), DIM_W'(4));
        fill_image();
        hold_left = HOLD_CYCLES;
        repeat (40) sample_point(pick_coord(img_w), pick_coord(img_h), 1'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_result();
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[bilinear_image_sampler] ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 10;
        recv_idle_pct = 63;
        test_reset_size_corners();
        test_dimension_limits();
        test_random_sets(PHASE_WORDS);
        send_idle_pct = 63;
        recv_idle_pct = 10;
        test_random_sets(PHASE_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sets(PHASE_WORDS);
        test_backpressure();
        drain_results();
        if (errors == 0)
            $display("[bilinear_image_sampler] OK");
        else
            $display("[bilinear_image_sampler] ERROR");
        $finish;
    end

endmodule
